/* design/vsfm_pkg.sv */
`timescale 1ns / 1ps

package vsfm_pkg;

   localparam int COORD_BITS_DEFAULT = 8;
   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam int COLOR_BITS = 8;
   localparam int MASK_BITS = 6;
   localparam int SIDE_COUNT = 4;

   // vis_mask bit positions
   localparam int VIS_TOP = 4;
   localparam int VIS_BOTTOM = 5;

   typedef enum logic [2:0] {
      FACE_TOP    = 3'd0,
      FACE_BOTTOM = 3'd1,
      FACE_NEG_X  = 3'd2,
      FACE_POS_X  = 3'd3,
      FACE_NEG_Y  = 3'd4,
      FACE_POS_Y  = 3'd5
   } face_kind_type;

   // faces still owed by one voxel, in output order from bit 0 up
   typedef struct packed {
      logic                  bot;
      logic [SIDE_COUNT-1:0] fin;
      logic [SIDE_COUNT-1:0] chg;
      logic                  top;
   } face_plan_type;

   localparam int PLAN_BITS = $bits(face_plan_type);
   localparam int SLOT_BITS = $clog2(PLAN_BITS);

   localparam logic [SLOT_BITS-1:0] SLOT_TOP = SLOT_BITS'(0);
   localparam logic [SLOT_BITS-1:0] SLOT_CHG = SLOT_BITS'(1);
   localparam logic [SLOT_BITS-1:0] SLOT_FIN = SLOT_BITS'(1 + SIDE_COUNT);
   localparam logic [SLOT_BITS-1:0] SLOT_BOT = SLOT_BITS'(1 + 2 * SIDE_COUNT);

endpackage

/* design/vsfm_front.sv */
`timescale 1ns / 1ps

module vsfm_front #(
   parameter int COORD_BITS = vsfm_pkg::COORD_BITS_DEFAULT,
   parameter int ENTRY_BITS = 5 * COORD_BITS + 3 * vsfm_pkg::COLOR_BITS + vsfm_pkg::PLAN_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [COORD_BITS-1:0]             req_col_x,
   input  logic [COORD_BITS-1:0]             req_col_y,
   input  logic [COORD_BITS-1:0]             req_z_pos,
   input  logic [vsfm_pkg::COLOR_BITS-1:0]   req_color,
   input  logic [vsfm_pkg::MASK_BITS-1:0]    req_vis_mask,
   input  logic                              req_first_in_slab,
   input  logic                              req_last_in_slab,
   input  logic                              queue_full,
   output logic                              push,
   output logic [ENTRY_BITS-1:0]             entry
);
   import vsfm_pkg::*;

   logic [COORD_BITS-1:0] run_start_ff, run_start_in;
   logic [COLOR_BITS-1:0] run_color_ff, run_color_in;
   logic [MASK_BITS-1:0]  run_mask_ff, run_mask_in;
   logic                  run_open_ff, run_open_in;

   logic          accept;
   logic          open_kept;
   logic          change;
   face_plan_type plan;

   assign req_stall = queue_full;
   assign accept    = req_valid & ~queue_full;

   always_comb begin
      open_kept = run_open_ff & ~req_first_in_slab;
      change    = open_kept & (req_color != run_color_ff);

      if (open_kept & ~change) begin
         run_start_in = run_start_ff;
         run_color_in = run_color_ff;
         run_mask_in  = run_mask_ff;
      end else begin
         run_start_in = req_z_pos;
         run_color_in = req_color;
         run_mask_in  = req_vis_mask;
      end
      run_open_in = ~req_last_in_slab;

      plan.top = req_first_in_slab & req_vis_mask[VIS_TOP];
      plan.chg = change ? run_mask_ff[SIDE_COUNT-1:0] : '0;
      plan.fin = req_last_in_slab ? run_mask_in[SIDE_COUNT-1:0] : '0;
      plan.bot = req_last_in_slab & run_mask_in[VIS_BOTTOM];

      push  = accept & (plan != '0);
      entry = {plan, req_col_x, req_col_y, req_z_pos, req_color,
               run_start_ff, run_color_ff, run_start_in, run_color_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_start_ff <= '0;
         run_color_ff <= '0;
         run_mask_ff  <= '0;
         run_open_ff  <= 1'b0;
      end else if (accept) begin
         run_start_ff <= run_start_in;
         run_color_ff <= run_color_in;
         run_mask_ff  <= run_mask_in;
         run_open_ff  <= run_open_in;
      end
   end

endmodule

/* design/vsfm_queue.sv */
`timescale 1ns / 1ps

module vsfm_queue #(
   parameter int DATA_BITS = 8,
   parameter int DEPTH = vsfm_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic [DATA_BITS-1:0] push_data,
   output logic                 full,
   input  logic                 pop,
   output logic                 head_valid,
   output logic [DATA_BITS-1:0] head_data
);
   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [DATA_BITS-1:0] slot_ff [DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;

   assign full       = (count_ff == CNT_BITS'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push & ~pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop & ~push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* design/vsfm_back.sv */
`timescale 1ns / 1ps

module vsfm_back #(
   parameter int COORD_BITS = vsfm_pkg::COORD_BITS_DEFAULT,
   parameter int ENTRY_BITS = 5 * COORD_BITS + 3 * vsfm_pkg::COLOR_BITS + vsfm_pkg::PLAN_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            head_valid,
   input  logic [ENTRY_BITS-1:0]           head_data,
   output logic                            pop,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [2:0]                      rsp_face_kind,
   output logic [COORD_BITS-1:0]           rsp_face_x,
   output logic [COORD_BITS-1:0]           rsp_face_y,
   output logic [COORD_BITS:0]             rsp_z_low,
   output logic [COORD_BITS:0]             rsp_z_high,
   output logic [vsfm_pkg::COLOR_BITS-1:0] rsp_face_color,
   output logic                            rsp_last_face
);
   import vsfm_pkg::*;

   face_plan_type         head_plan;
   logic [COORD_BITS-1:0] head_x, head_y, head_z, chg_start, fin_start;
   logic [COLOR_BITS-1:0] head_color, chg_color, fin_color;

   logic [PLAN_BITS-1:0]  done_ff, done_in;
   logic [PLAN_BITS-1:0]  pending, rest;
   logic [SLOT_BITS-1:0]  pick;
   logic [SLOT_BITS-1:0]  side;
   logic                  found;
   logic                  fire;
   logic [COORD_BITS:0]   z_here, z_next;

   logic                  valid_ff, valid_in;
   face_kind_type         kind_ff, kind_in;
   logic [COORD_BITS-1:0] x_ff, y_ff;
   logic [COORD_BITS:0]   zl_ff, zl_in, zh_ff, zh_in;
   logic [COLOR_BITS-1:0] color_ff, color_in;
   logic                  last_ff, last_in;

   assign {head_plan, head_x, head_y, head_z, head_color,
           chg_start, chg_color, fin_start, fin_color} = head_data;

   assign z_here = {1'b0, head_z};
   assign z_next = {1'b0, head_z} + 1'b1;

   always_comb begin
      pending = head_plan & ~done_ff;
      pick    = '0;
      found   = 1'b0;
      for (int i = 0; i < PLAN_BITS; i++) begin
         if (pending[i] && !found) begin
            pick  = SLOT_BITS'(i);
            found = 1'b1;
         end
      end
      rest       = pending;
      rest[pick] = 1'b0;

      fire = head_valid & (~valid_ff | ~rsp_stall);
      pop  = fire & (rest == '0);

      done_in = done_ff;
      if (pop) begin
         done_in = '0;
      end else if (fire) begin
         done_in = done_ff | (pending & ~rest);
      end

      side     = '0;
      kind_in  = FACE_TOP;
      zl_in    = z_here;
      zh_in    = z_here;
      color_in = head_color;
      case (pick)
         SLOT_TOP: begin
            kind_in = FACE_TOP;
         end
         SLOT_BOT: begin
            kind_in = FACE_BOTTOM;
            zl_in   = z_next;
            zh_in   = z_next;
         end
         default: begin
            if (pick < SLOT_FIN) begin
               side     = pick - SLOT_CHG;
               zl_in    = {1'b0, chg_start};
               zh_in    = z_here;
               color_in = chg_color;
            end else begin
               side     = pick - SLOT_FIN;
               zl_in    = {1'b0, fin_start};
               zh_in    = z_next;
               color_in = fin_color;
            end
            kind_in = face_kind_type'(FACE_NEG_X + 3'(side));
         end
      endcase
      last_in = (rest == '0);

      if (fire) begin
         valid_in = 1'b1;
      end else if (~rsp_stall) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         done_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         kind_ff  <= kind_in;
         x_ff     <= head_x;
         y_ff     <= head_y;
         zl_ff    <= zl_in;
         zh_ff    <= zh_in;
         color_ff <= color_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_face_kind  = kind_ff;
   assign rsp_face_x     = x_ff;
   assign rsp_face_y     = y_ff;
   assign rsp_z_low      = zl_ff;
   assign rsp_z_high     = zh_ff;
   assign rsp_face_color = color_ff;
   assign rsp_last_face  = last_ff;

endmodule

/* design/voxel_slab_face_mesher.sv */
`timescale 1ns / 1ps
// Voxel slab face mesher.
// Input channel req_*: one voxel per beat (column x/y, z, color, face
// visibility mask, first/last marks), accepted when req_valid is high and
// req_stall is low. Output channel rsp_*: one face per beat (kind, x, y,
// z span, color, last_face on the final face of a voxel).
// The front tracks the open run and queues a face plan for every voxel that
// yields faces. Voxels with no faces leave nothing in the queue. The back
// emits one face per cycle from the queue head while rsp_stall does not hold
// the output register, and pops a voxel's plan only with its last face; a voxel
// yields 0 to 9 faces. With an empty queue, an accepted voxel's plan is written
// into the queue and its first face is then loaded into the output register.
// req_stall rises only when the QUEUE_DEPTH-entry plan queue is full.
// While rsp_stall is high the output register holds its face and the back
// waits; the front keeps taking voxels until the queue fills.
// Reset (synchronous) closes any open run and empties the queue and the
// output register.
module voxel_slab_face_mesher #(
   parameter int COORD_BITS = vsfm_pkg::COORD_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = vsfm_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [COORD_BITS-1:0]           req_col_x,
   input  logic [COORD_BITS-1:0]           req_col_y,
   input  logic [COORD_BITS-1:0]           req_z_pos,
   input  logic [vsfm_pkg::COLOR_BITS-1:0] req_color,
   input  logic [vsfm_pkg::MASK_BITS-1:0]  req_vis_mask,
   input  logic                            req_first_in_slab,
   input  logic                            req_last_in_slab,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [2:0]                      rsp_face_kind,
   output logic [COORD_BITS-1:0]           rsp_face_x,
   output logic [COORD_BITS-1:0]           rsp_face_y,
   output logic [COORD_BITS:0]             rsp_z_low,
   output logic [COORD_BITS:0]             rsp_z_high,
   output logic [vsfm_pkg::COLOR_BITS-1:0] rsp_face_color,
   output logic                            rsp_last_face
);
   import vsfm_pkg::*;

   localparam int ENTRY_BITS = 5 * COORD_BITS + 3 * COLOR_BITS + PLAN_BITS;

   logic                  push, pop, queue_full, head_valid;
   logic [ENTRY_BITS-1:0] entry, head_data;

   vsfm_front #(
      .COORD_BITS (COORD_BITS),
      .ENTRY_BITS (ENTRY_BITS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_col_x         (req_col_x),
      .req_col_y         (req_col_y),
      .req_z_pos         (req_z_pos),
      .req_color         (req_color),
      .req_vis_mask      (req_vis_mask),
      .req_first_in_slab (req_first_in_slab),
      .req_last_in_slab  (req_last_in_slab),
      .queue_full        (queue_full),
      .push              (push),
      .entry             (entry)
   );

   vsfm_queue #(
      .DATA_BITS (ENTRY_BITS),
      .DEPTH     (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   vsfm_back #(
      .COORD_BITS (COORD_BITS),
      .ENTRY_BITS (ENTRY_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_data      (head_data),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_face_kind  (rsp_face_kind),
      .rsp_face_x     (rsp_face_x),
      .rsp_face_y     (rsp_face_y),
      .rsp_z_low      (rsp_z_low),
      .rsp_z_high     (rsp_z_high),
      .rsp_face_color (rsp_face_color),
      .rsp_last_face  (rsp_last_face)
   );

endmodule
